### design/fsd_pkg.sv
// Shared types, constants and register codes for the error-diffusion ditherer.
package fsd_pkg;

    localparam int PIXEL_BITS     = 8;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int ERR_BITS       = 11;
    localparam int LINE_W_BITS    = 13;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH = 1'd1;

    localparam logic [PIXEL_BITS-1:0]  THRESHOLD_RST  = 8'd160;
    localparam logic [LINE_W_BITS-1:0] LINE_WIDTH_RST = 13'd640;
    localparam logic [PIXEL_BITS-1:0]  PIX_WHITE      = 8'hFF;
    localparam logic [PIXEL_BITS-1:0]  PIX_BLACK      = 8'h00;

    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] gray_pixel;
        logic                  frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] mono_pixel;
        logic                  row_end;
    } t_out_beat;

    // write requests from the pixel stage to the row buffer
    typedef struct packed {
        logic wr_en;
        t_err wr_data;
        logic pend_en;
        t_err pend_data;
    } t_buf_wr;

endpackage

### design/floyd_steinberg_dither_top.sv
// Top level of the Floyd-Steinberg error-diffusion ditherer.
//
// Input channel: i_in_valid / o_in_stall carry one gray pixel per beat in
// raster order; frame_start marks the first pixel of an image, clears the
// carried errors, restarts the column count and marks the first row.
// Output channel: o_out_valid / i_out_stall carry one mono pixel per input
// beat, with row_end on the last pixel of each row.
// An accepted beat is held in the pixel stage register and then in the result
// register, which drives the output.
// Throughput is one pixel per clock while the receiver does not stall; the
// right-error feedback closes in the single pixel stage, and the row buffer takes one write and one read a cycle.
// When the receiver stalls, the result register holds, the pixel stage holds
// behind it, and o_in_stall rises only once both are full.
// Synchronous reset loads threshold 160 and width 640, clears the carries and
// starts in the first row; the row buffer needs no clearing, as the first
// row never reads it.
// Configuration writes (threshold, line width) must be made only while idle; the block itself does not enforce this.
module floyd_steinberg_dither_top
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_beat                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_beat               o_out_data,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [LINE_W_BITS-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [PIXEL_BITS-1:0] threshold;
    logic [WW-1:0]         width;
    logic                  accept;
    logic [AW-1:0]         col;
    logic                  last;
    t_err                  above;
    t_buf_wr               buf_wr;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         pend_addr;

    fsd_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .WW        (WW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_threshold (threshold),
        .o_width     (width)
    );

    fsd_colgen #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW),
        .WW        (WW)
    ) u_colgen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_start (i_in_data.frame_start),
        .i_width       (width),
        .o_col         (col),
        .o_last        (last)
    );

    fsd_rowbuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_rowbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr   (col),
        .i_wr        (buf_wr),
        .i_wr_addr   (wr_addr),
        .i_pend_addr (pend_addr),
        .o_rd_data   (above)
    );

    fsd_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .i_col       (col),
        .i_last      (last),
        .i_threshold (threshold),
        .i_above     (above),
        .o_wr        (buf_wr),
        .o_wr_addr   (wr_addr),
        .o_pend_addr (pend_addr),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### design/fsd_cfg.sv
// Configuration registers and effective row width.
module fsd_cfg
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [LINE_W_BITS-1:0]  i_cfg_wdata,
    output logic [PIXEL_BITS-1:0]   o_threshold,
    output logic [WW-1:0]           o_width
);

    localparam int CW = (WW > LINE_W_BITS) ? WW : LINE_W_BITS;

    logic [PIXEL_BITS-1:0]  r_threshold;
    logic [LINE_W_BITS-1:0] r_line_width;
    logic [CW-1:0]          lw_ext;
    logic [CW-1:0]          lw_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_line_width <= LINE_WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:  r_threshold  <= i_cfg_wdata[PIXEL_BITS-1:0];
                CFG_LINE_WIDTH: r_line_width <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        lw_ext = CW'(r_line_width);
        if (lw_ext == '0) begin
            lw_eff = CW'(1);
        end else if (lw_ext > CW'(MAX_WIDTH)) begin
            lw_eff = CW'(MAX_WIDTH);
        end else begin
            lw_eff = lw_ext;
        end
    end

    assign o_threshold = r_threshold;
    assign o_width     = WW'(lw_eff);

endmodule

### design/fsd_colgen.sv
// Column counter on the accept side: column and row end of each incoming beat.
module fsd_colgen
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH),
    parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_frame_start,
    input  logic [WW-1:0] i_width,
    output logic [AW-1:0] o_col,
    output logic          o_last
);

    logic [AW-1:0] r_col;
    logic [AW-1:0] base;
    logic [WW-1:0] wm1;

    always_comb begin
        base   = i_frame_start ? '0 : r_col;
        wm1    = i_width - WW'(1);
        o_col  = (WW'(base) >= wm1) ? AW'(wm1) : base;
        o_last = (WW'(o_col) == wm1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_accept) begin
            r_col <= o_last ? '0 : AW'(o_col + AW'(1));
        end
    end

endmodule

### design/fsd_rowbuf.sv
// Row error buffer: one write port, registered read with bypass of late writes.
module fsd_rowbuf
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  t_buf_wr       i_wr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [AW-1:0] i_pend_addr,
    output t_err          o_rd_data
);

    t_err          mem [MAX_WIDTH];
    t_err          r_rd_mem;
    logic          r_byp_v;
    t_err          r_byp_data;
    logic          r_pend_v;
    logic [AW-1:0] r_pend_addr;
    t_err          r_pend_data;

    logic          port_en;
    logic [AW-1:0] port_addr;
    t_err          port_data;

    // the end-of-row entry is parked in a pending register; the next beat is at column 0 and leaves the port free
    always_comb begin
        port_en   = i_wr.wr_en || r_pend_v;
        port_addr = i_wr.wr_en ? i_wr_addr : r_pend_addr;
        port_data = i_wr.wr_en ? i_wr.wr_data : r_pend_data;
    end

    always_ff @(posedge i_clk) begin
        if (port_en) begin
            mem[port_addr] <= port_data;
        end
        if (i_rd_en) begin
            r_rd_mem <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_byp_v  <= 1'b0;
        end else begin
            r_pend_v <= i_wr.pend_en;
            if (i_rd_en) begin
                r_byp_v <= (i_wr.pend_en && i_pend_addr == i_rd_addr) ||
                           (port_en && port_addr == i_rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.pend_en) begin
            r_pend_addr <= i_pend_addr;
            r_pend_data <= i_wr.pend_data;
        end
        if (i_rd_en) begin
            r_byp_data <= (i_wr.pend_en && i_pend_addr == i_rd_addr) ?
                          i_wr.pend_data : port_data;
        end
    end

    assign o_rd_data = r_byp_v ? r_byp_data : r_rd_mem;

endmodule

### design/fsd_core.sv
// Pixel stage: threshold, error split, error carries and result register.
module fsd_core
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_beat              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_accept,
    input  logic [AW-1:0]         i_col,
    input  logic                  i_last,
    input  logic [PIXEL_BITS-1:0] i_threshold,
    input  t_err                  i_above,
    output t_buf_wr               o_wr,
    output logic [AW-1:0]         o_wr_addr,
    output logic [AW-1:0]         o_pend_addr,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data
);

    localparam int CB = ERR_BITS + 2;
    localparam int PB = ERR_BITS + 4;

    logic                  r_stg_v;
    logic [PIXEL_BITS-1:0] r_gray;
    logic                  r_fs;
    logic [AW-1:0]         r_col;
    logic                  r_last;

    t_err r_right;
    t_err r_below;
    t_err r_blc;
    logic r_first;

    logic      r_out_v;
    t_out_beat r_out;

    logic                 fire;
    t_err                 re, bc, blc, above;
    logic                 fr;
    logic signed [CB-1:0] corr;
    logic signed [CB-1:0] ediff;
    logic                 white;
    t_err                 e;
    logic signed [PB-1:0] e_ext;
    t_err                 s1, s3, s5, s7;
    logic signed [PB-1:0] p1, p3, p5, p7;
    t_err                 n_blc;

    assign fire       = r_stg_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_stg_v && !fire;
    assign o_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        re    = r_fs ? '0 : r_right;
        bc    = r_fs ? '0 : r_below;
        blc   = r_fs ? '0 : r_blc;
        fr    = r_fs || r_first;
        above = fr ? '0 : i_above;
        corr  = $signed({{(CB-PIXEL_BITS){1'b0}}, r_gray})
              + $signed({{2{re[ERR_BITS-1]}}, re})
              + $signed({{2{above[ERR_BITS-1]}}, above});
        white = corr > $signed({{(CB-PIXEL_BITS){1'b0}}, i_threshold});
        ediff = white ? corr - $signed({{(CB-PIXEL_BITS){1'b0}}, PIX_WHITE}) : corr;
        if (ediff > $signed(CB'(1023))) begin
            e = 11'sd1023;
        end else if (ediff < -$signed(CB'(1024))) begin
            e = -11'sd1024;
        end else begin
            e = ediff[ERR_BITS-1:0];
        end
        e_ext = $signed({{(PB-ERR_BITS){e[ERR_BITS-1]}}, e});
        p1    = e_ext >>> 4;
        p3    = (e_ext * $signed(PB'(3))) >>> 4;
        p5    = (e_ext * $signed(PB'(5))) >>> 4;
        p7    = (e_ext * $signed(PB'(7))) >>> 4;
        s1    = p1[ERR_BITS-1:0];
        s3    = p3[ERR_BITS-1:0];
        s5    = p5[ERR_BITS-1:0];
        s7    = p7[ERR_BITS-1:0];
        n_blc = bc + s5;
    end

    always_comb begin
        o_wr.wr_en     = fire && (r_col != '0);
        o_wr.wr_data   = blc + s3;
        o_wr.pend_en   = fire && r_last;
        o_wr.pend_data = n_blc;
        o_wr_addr      = AW'(r_col - AW'(1));
        o_pend_addr    = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_v <= 1'b0;
            r_out_v <= 1'b0;
            r_right <= '0;
            r_below <= '0;
            r_blc   <= '0;
            r_first <= 1'b1;
        end else begin
            if (o_accept) begin
                r_stg_v <= 1'b1;
            end else if (fire) begin
                r_stg_v <= 1'b0;
            end
            if (fire) begin
                r_out_v <= 1'b1;
                r_right <= r_last ? '0 : s7;
                r_below <= r_last ? '0 : s1;
                r_blc   <= r_last ? '0 : n_blc;
                r_first <= r_last ? 1'b0 : fr;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_gray <= i_in_data.gray_pixel;
            r_fs   <= i_in_data.frame_start;
            r_col  <= i_col;
            r_last <= i_last;
        end
        if (fire) begin
            r_out.mono_pixel <= white ? PIX_WHITE : PIX_BLACK;
            r_out.row_end    <= r_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
